// File: rtl/trimmed_block_average_filter_core_assert.svh
// Assertion helpers for the trimmed block average filter.
`ifndef TRIMMED_BLOCK_AVERAGE_FILTER_CORE_ASSERT_SVH
`define TRIMMED_BLOCK_AVERAGE_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBAF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbaf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TBAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbaf assertion failed");

`endif

// File: rtl/tbaf_pkg.sv
`default_nettype none

package tbaf_pkg;

  localparam int unsigned BLOCK_LEN  = 10;
  localparam int unsigned WINDOW_LEN = 8;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned EXT_W    = SAMPLE_W + 1;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned SPREAD_W = 16;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned ABS_W    = 12;

  localparam logic [EXT_W-1:0] ABOVE_ANY = EXT_W'(1 << SAMPLE_W);
  localparam logic [PCT_W-1:0] PCT_RESET = 7'd10;
  localparam logic [ABS_W-1:0] ABS_RESET = 12'd50;

  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int unsigned POS_W      = $clog2(BLOCK_LEN);
  localparam int unsigned BSUM_W     = $clog2(BLOCK_LEN * SAMPLE_MAX + 1);
  localparam int unsigned MEAN_DIV   = BLOCK_LEN - 2;

  localparam int unsigned WIN_CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned WIN_IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned WSUM_W    = $clog2(WINDOW_LEN * SAMPLE_MAX + 1);
  localparam int unsigned RAM_AW    = WIN_IDX_W + 1;
  localparam int unsigned RAM_DEPTH = 1 << RAM_AW;

  localparam int unsigned PERCENT_SCALE = 100;
  localparam int unsigned PROD_W = SPREAD_W + $clog2(PERCENT_SCALE);
  localparam int unsigned RHS_W  = EXT_W + PCT_W;

  // Shared divider: the quotient never exceeds one sample code.
  localparam int unsigned QUO_W  = SAMPLE_W;
  localparam int unsigned DVD_W  = (BSUM_W > WSUM_W) ? BSUM_W : WSUM_W;
  localparam int unsigned MDIV_W = $clog2(MEAN_DIV + 1);
  localparam int unsigned DIVR_W = (MDIV_W > WIN_CNT_W) ? MDIV_W : WIN_CNT_W;
  localparam int unsigned DIVC_W = (DVD_W > DIVR_W + QUO_W) ? DVD_W : DIVR_W + QUO_W;
  localparam int unsigned STEP_W = $clog2(QUO_W);

  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned REG_IDX_BIT = 2;
  localparam logic REG_PCT = 1'b0;
  localparam logic REG_ABS = 1'b1;

  localparam logic CH_A = 1'b0;
  localparam logic CH_B = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
  } in_word_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered_a;
    logic [SAMPLE_W-1:0] filtered_b;
    logic                updated_a;
    logic                updated_b;
    logic [COUNT_W-1:0]  block_seq;
    logic [COUNT_W-1:0]  rejected_blocks;
  } out_word_t;

  typedef struct packed {
    logic [PCT_W-1:0] pct;
    logic [ABS_W-1:0] abs;
  } cfg_t;

  typedef struct packed {
    logic track;
    logic mul;
    logic reject;
    logic push;
    logic div_avg;
    logic held;
    logic finish;
    logic ch;
  } cmd_t;

  typedef struct packed {
    logic last_sample;
    logic reject;
    logic div_busy;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/tbaf_ram.sv
`default_nettype none

module tbaf_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/tbaf_div.sv
`default_nettype none

module tbaf_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [tbaf_pkg::DVD_W-1:0]   dividend_i,
  input  wire logic [tbaf_pkg::DIVR_W-1:0]  divisor_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic      [tbaf_pkg::QUO_W-1:0]   quotient_o
);

  import tbaf_pkg::*;

  logic [DIVC_W-1:0] rem_q;
  logic [DIVC_W-1:0] dsh_q;
  logic [QUO_W-1:0]  quo_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;
  logic              fits;

  // Restoring division, one quotient bit per cycle from the top bit down.
  assign fits = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (step_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= DIVC_W'(dividend_i);
      dsh_q  <= DIVC_W'(divisor_i) << (QUO_W - 1);
      quo_q  <= '0;
      step_q <= STEP_W'(QUO_W - 1);
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q  <= {quo_q[QUO_W-2:0], fits};
      dsh_q  <= dsh_q >> 1;
      step_q <= step_q - STEP_W'(1);
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: rtl/tbaf_regs.sv
`default_nettype none

module tbaf_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tbaf_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tbaf_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tbaf_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output tbaf_pkg::cfg_t                     cfg_o
);

  import tbaf_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pct <= PCT_RESET;
      cfg_q.abs <= ABS_RESET;
    end else if (wr_en) begin
      case (paddr[REG_IDX_BIT])
        REG_PCT: cfg_q.pct <= pwdata[PCT_W-1:0];
        REG_ABS: cfg_q.abs <= pwdata[ABS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_IDX_BIT])
      REG_PCT: prdata = PDATA_W'(cfg_q.pct);
      REG_ABS: prdata = PDATA_W'(cfg_q.abs);
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/tbaf_datapath.sv
`default_nettype none

module tbaf_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  tbaf_pkg::in_word_t in_data_i,
  input  tbaf_pkg::cfg_t     cfg_i,
  input  tbaf_pkg::cmd_t     cmd_i,
  output tbaf_pkg::status_t  status_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tbaf_pkg::out_word_t out_data_o
);

  import tbaf_pkg::*;

  logic [SAMPLE_W-1:0] samp [2];

  logic [POS_W-1:0]    pos_q;
  logic [BSUM_W-1:0]   bsum_q [2];
  logic [SAMPLE_W-1:0] lg_q   [2];
  logic [SAMPLE_W-1:0] slg_q  [2];
  logic [EXT_W-1:0]    sm_q   [2];
  logic [EXT_W-1:0]    ssm_q  [2];

  logic [WSUM_W-1:0]    wsum_q  [2];
  logic [WIN_IDX_W-1:0] widx_q  [2];
  logic [WIN_CNT_W-1:0] wfill_q [2];
  logic [SAMPLE_W-1:0]  held_q  [2];
  logic                 ok_q    [2];

  logic [COUNT_W-1:0] seq_q;
  logic [COUNT_W-1:0] rej_q;

  logic              spread_gt_q;
  logic [PROD_W-1:0] lhs_q;
  logic [RHS_W-1:0]  rhs_q;

  out_word_t out_q;
  logic      out_valid_q;

  logic                ch;
  logic                last;
  logic [SPREAD_W-1:0] spread;
  logic [SPREAD_W-1:0] excess;
  logic [BSUM_W-1:0]   trimmed;
  logic [SAMPLE_W-1:0] mean;
  logic [SAMPLE_W-1:0] old_val;
  logic [SAMPLE_W-1:0] rdata;
  logic [WSUM_W-1:0]   wsum_new;
  logic [RAM_AW-1:0]   ram_addr;
  logic                div_start;
  logic [DVD_W-1:0]    dividend;
  logic [DIVR_W-1:0]   divisor;
  logic                div_busy;
  logic                div_done;
  logic [QUO_W-1:0]    quotient;

  assign samp[0] = in_data_i.sample_a;
  assign samp[1] = in_data_i.sample_b;
  assign ch      = cmd_i.ch;
  assign last    = (pos_q == POS_W'(BLOCK_LEN - 1));

  // Block statistics, updated once per accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      for (int c = 0; c < 2; c++) begin
        bsum_q[c] <= '0;
        lg_q[c]   <= '0;
        slg_q[c]  <= '0;
        sm_q[c]   <= ABOVE_ANY;
        ssm_q[c]  <= ABOVE_ANY;
      end
    end else if (cmd_i.finish) begin
      pos_q <= '0;
      for (int c = 0; c < 2; c++) begin
        bsum_q[c] <= '0;
        lg_q[c]   <= '0;
        slg_q[c]  <= '0;
        sm_q[c]   <= ABOVE_ANY;
        ssm_q[c]  <= ABOVE_ANY;
      end
    end else if (cmd_i.track) begin
      if (!last) begin
        pos_q <= pos_q + POS_W'(1);
      end
      for (int c = 0; c < 2; c++) begin
        bsum_q[c] <= bsum_q[c] + BSUM_W'(samp[c]);
        if (samp[c] > lg_q[c]) begin
          slg_q[c] <= lg_q[c];
          lg_q[c]  <= samp[c];
        end else if (samp[c] > slg_q[c]) begin
          slg_q[c] <= samp[c];
        end
        if (EXT_W'(samp[c]) < sm_q[c]) begin
          ssm_q[c] <= sm_q[c];
          sm_q[c]  <= EXT_W'(samp[c]);
        end else if (EXT_W'(samp[c]) < ssm_q[c]) begin
          ssm_q[c] <= EXT_W'(samp[c]);
        end
      end
    end
  end

  // The limit test spread > floor(min*pct/100) + abs is done without a divide:
  // it holds exactly when spread exceeds abs and 100*(spread-abs) > min*pct.
  assign spread = SPREAD_W'(slg_q[ch]) - SPREAD_W'(ssm_q[ch]);
  assign excess = spread - SPREAD_W'(cfg_i.abs);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      spread_gt_q <= (spread > SPREAD_W'(cfg_i.abs));
      lhs_q       <= PROD_W'(excess) * PROD_W'(PERCENT_SCALE);
      rhs_q       <= RHS_W'(sm_q[ch]) * RHS_W'(cfg_i.pct);
    end
  end

  assign trimmed = bsum_q[ch] - BSUM_W'(lg_q[ch]) - BSUM_W'(sm_q[ch]);
  // The trimmed mean divides by a power of two, so it is only a shift.
  assign mean    = SAMPLE_W'(trimmed / MEAN_DIV);

  assign div_start = cmd_i.div_avg;
  assign dividend  = DVD_W'(wsum_q[ch]);
  assign divisor   = DIVR_W'(wfill_q[ch]);

  tbaf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign ram_addr = {ch, widx_q[ch]};

  tbaf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (ram_addr),
    .wdata_i (mean),
    .re_i    (cmd_i.mul),
    .raddr_i (ram_addr),
    .rdata_o (rdata)
  );

  // Slots at or beyond the fill count have never been written and count as zero.
  assign old_val  = (wfill_q[ch] == WIN_CNT_W'(WINDOW_LEN)) ? rdata : '0;
  assign wsum_new = wsum_q[ch] - WSUM_W'(old_val) + WSUM_W'(mean);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        wsum_q[c]  <= '0;
        widx_q[c]  <= '0;
        wfill_q[c] <= '0;
        held_q[c]  <= '0;
        ok_q[c]    <= 1'b0;
      end
      seq_q <= '0;
      rej_q <= '0;
    end else begin
      if (cmd_i.push) begin
        wsum_q[ch] <= wsum_new;
        if (widx_q[ch] == WIN_IDX_W'(WINDOW_LEN - 1)) begin
          widx_q[ch] <= '0;
        end else begin
          widx_q[ch] <= widx_q[ch] + WIN_IDX_W'(1);
        end
        if (wfill_q[ch] != WIN_CNT_W'(WINDOW_LEN)) begin
          wfill_q[ch] <= wfill_q[ch] + WIN_CNT_W'(1);
        end
      end
      if (cmd_i.held) begin
        held_q[ch] <= quotient;
        ok_q[ch]   <= 1'b1;
      end
      if (cmd_i.reject) begin
        ok_q[ch] <= 1'b0;
        rej_q    <= rej_q + COUNT_W'(1);
      end
      if (cmd_i.finish) begin
        seq_q <= seq_q + COUNT_W'(1);
      end
    end
  end

  // Result word register: a finished word waits here while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.filtered_a      <= held_q[0];
      out_q.filtered_b      <= held_q[1];
      out_q.updated_a       <= ok_q[0];
      out_q.updated_b       <= ok_q[1];
      out_q.block_seq       <= seq_q + COUNT_W'(1);
      out_q.rejected_blocks <= rej_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.last_sample = last;
  assign status_o.reject      = spread_gt_q && (lhs_q > PROD_W'(rhs_q));
  assign status_o.div_busy    = div_busy;
  assign status_o.div_done    = div_done;
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

// File: rtl/tbaf_ctrl.sv
`default_nettype none

module tbaf_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  tbaf_pkg::status_t status_i,
  output tbaf_pkg::cmd_t    cmd_o
);

  import tbaf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_PUSH = 3'd4;
  localparam logic [2:0] S_AVG  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q, state_d;
  logic       ch_q, ch_d;
  cmd_t       cmd;

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    cmd     = '0;
    cmd.ch  = ch_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.track = 1'b1;
          if (status_i.last_sample) begin
            state_d = S_MUL;
            ch_d    = CH_A;
          end
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (status_i.reject) begin
          cmd.reject = 1'b1;
          if (ch_q == CH_B) begin
            state_d = S_DONE;
          end else begin
            ch_d    = CH_B;
            state_d = S_MUL;
          end
        end else begin
          cmd.push = 1'b1;
          state_d  = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.div_avg = 1'b1;
        state_d     = S_AVG;
      end
      S_AVG: begin
        if (status_i.div_done) begin
          cmd.held = 1'b1;
          if (ch_q == CH_B) begin
            state_d = S_DONE;
          end else begin
            ch_d    = CH_B;
            state_d = S_MUL;
          end
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd.finish = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= CH_A;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o      = cmd;

endmodule

`default_nettype wire

// File: rtl/trimmed_block_average_filter_core.sv
// Two-channel trimmed block average filter.
// Input channel: in_valid_i / in_stall_o carry one word with a sample of
// channel A and one of channel B. A word is taken when valid is high and
// stall is low. Inside a block one word is taken every cycle.
// After the last word of a block in_stall_o rises while the block is closed:
// per channel the spread test (states S_MUL and S_EVAL), and for an accepted
// channel a start of the shared radix-2 divider (S_PUSH), then S_AVG while it
// forms the window average, one quotient bit a cycle. Block close then ends in
// S_DONE, which waits until the output register is free.
// Output channel: out_valid_o / out_stall_i carry one result word per block,
// from a register. A stalled word holds; the next block's words are still
// taken, and only the last step of its close waits until the held word has gone.
// Configuration: APB writes at 0 (spread percent) and 4 (spread absolute),
// always ready; write only while the block is idle.
// Reset (rst_ni low, asynchronous) clears the block, window, counters and
// loads the register defaults; no clearing pass is needed.
`default_nettype none
`include "trimmed_block_average_filter_core_assert.svh"

module trimmed_block_average_filter_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  tbaf_pkg::in_word_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output tbaf_pkg::out_word_t                out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tbaf_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tbaf_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tbaf_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  import tbaf_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  tbaf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tbaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tbaf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `TBAF_ASSERT_IMPL(a_out_rise_from_finish, clk_i, rst_ni, $rose(out_valid_o), $past(cmd.finish))
  `TBAF_ASSERT_NEXT(a_last_word_stalls, clk_i, rst_ni, in_accept && status.last_sample, in_stall_o)
  `TBAF_ASSERT_IMPL(a_div_start_idle, clk_i, rst_ni, cmd.div_avg, !status.div_busy)
  `TBAF_ASSERT_IMPL(a_finish_out_free, clk_i, rst_ni, cmd.finish, status.out_free && in_stall_o)

endmodule

`default_nettype wire
